[rtl/rbd_pkg.sv]
// rbd_pkg: shared constants, beat and config structs, and channel arithmetic
// for the rgba box downsample cascade. no dependencies.
`default_nettype none

package rbd_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_LEVELS = 4;
    localparam int HEIGHT_CAP = 2048;

    localparam int PIX_W    = 32;
    localparam int CH_W     = 8;
    localparam int NUM_CH   = 4;
    localparam int SUM_CH_W = CH_W + 1;
    localparam int SUM_W    = NUM_CH * SUM_CH_W;

    localparam int DIM_W   = 12;
    localparam int LVL_W   = 3;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WK_W    = COL_W + 1;
    localparam int ROW_W   = 11;
    localparam int HK_W    = ROW_W + 1;
    localparam int ADDR_W  = COL_W - 1;
    localparam int LV_W    = $clog2(MAX_LEVELS + 1);
    localparam int CNT_W   = 22;
    localparam int TOT_W   = (WK_W + HK_W - 1 > CNT_W + 1) ? (WK_W + HK_W - 1) : (CNT_W + 1);

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH    = 2'd0,
        REG_IMAGE_HEIGHT   = 2'd1,
        REG_HALVING_LEVELS = 2'd2,
        REG_FAKE_ALPHA     = 2'd3
    } reg_idx_t;

    // one beat between cells; fe marks the input pixel that ends the frame
    typedef struct packed {
        logic             valid;
        logic             have;
        logic             fe;
        logic [PIX_W-1:0] pix;
    } beat_t;

    typedef struct packed {
        logic            active;
        logic            head;
        logic [WK_W-1:0] wk;
        logic [HK_W-1:0] hk;
        logic [WK_W-1:0] w_even;
        logic [HK_W-1:0] h_even;
    } cell_cfg_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [SUM_W-1:0]  wdata;
    } ram_req_t;

    // per-channel horizontal pair sum, 9 bits per channel
    function automatic logic [SUM_W-1:0] pair_of(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = '0;
        for (int i = 0; i < NUM_CH; i++) begin
            s[i*SUM_CH_W +: SUM_CH_W] = {1'b0, a[i*CH_W +: CH_W]} + {1'b0, b[i*CH_W +: CH_W]};
        end
        return s;
    endfunction

    // vertical add of two pair sums, then truncating divide by four
    function automatic logic [PIX_W-1:0] combine(input logic [SUM_W-1:0] top,
                                                 input logic [SUM_W-1:0] bot);
        logic [PIX_W-1:0]    o;
        logic [SUM_CH_W:0]   v;
        o = '0;
        for (int i = 0; i < NUM_CH; i++) begin
            v = {1'b0, top[i*SUM_CH_W +: SUM_CH_W]} + {1'b0, bot[i*SUM_CH_W +: SUM_CH_W]};
            o[i*CH_W +: CH_W] = v[SUM_CH_W:2];
        end
        return o;
    endfunction

endpackage

`default_nettype wire

[rtl/rbd_ram.sv]
// rbd_ram: single-port line store with registered read data.
// generic, no package dependency.
`default_nettype none

module rbd_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 36
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

[rtl/rbd_cell.sv]
// rbd_cell: one halving stage of the cascade, two register stages deep.
// depends on rbd_pkg; its line store sits outside in an rbd_ram.
`default_nettype none

module rbd_cell (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      restart,
    input  wire rbd_pkg::cell_cfg_t        cfg,
    input  wire rbd_pkg::beat_t            in_beat,
    output logic                           in_ready,
    output rbd_pkg::beat_t                 out_beat,
    input  wire logic                      out_ready,
    output rbd_pkg::ram_req_t              ram_req,
    input  wire logic [rbd_pkg::SUM_W-1:0] ram_rdata
);

    logic [rbd_pkg::COL_W-1:0] col_reg, col_next;
    logic [rbd_pkg::ROW_W-1:0] row_reg, row_next;
    logic [rbd_pkg::PIX_W-1:0] held_reg, held_next;

    logic                      a_valid_reg, a_valid_next;
    logic                      a_comb_reg, a_comb_next;
    logic                      a_pass_reg, a_pass_next;
    logic                      a_fe_reg, a_fe_next;
    logic [rbd_pkg::PIX_W-1:0] a_pix_reg, a_pix_next;
    logic [rbd_pkg::SUM_W-1:0] a_pair_reg, a_pair_next;

    rbd_pkg::beat_t            out_beat_reg, out_beat_next;

    logic                      in_fire;
    logic                      b_ready;
    logic                      proc;
    logic                      track;
    logic [rbd_pkg::WK_W-1:0]  col_ext;
    logic [rbd_pkg::HK_W-1:0]  row_ext;
    logic                      drop;
    logic                      col_last;
    logic                      row_last;
    logic                      fe_here;
    logic                      pair_ok;
    logic [rbd_pkg::SUM_W-1:0] pair_sum;

    assign b_ready  = !out_beat_reg.valid || out_ready;
    assign in_ready = !a_valid_reg || b_ready;
    assign in_fire  = in_beat.valid && in_ready;
    assign out_beat = out_beat_reg;

    assign proc     = in_beat.have && cfg.active;
    // the head cell keeps the frame position even when no halving is on
    assign track    = in_beat.have && (cfg.active || cfg.head);
    assign col_ext  = {1'b0, col_reg};
    assign row_ext  = {1'b0, row_reg};
    assign drop     = (col_ext >= cfg.w_even) || (row_ext >= cfg.h_even);
    assign col_last = (col_ext + rbd_pkg::WK_W'(1)) >= cfg.wk;
    assign row_last = (row_ext + rbd_pkg::HK_W'(1)) >= cfg.hk;
    assign fe_here  = cfg.head && in_beat.have && col_last && row_last;
    assign pair_ok  = proc && !drop && col_reg[0];
    assign pair_sum = rbd_pkg::pair_of(held_reg, in_beat.pix);

    // even rows park the pair sum, odd rows fetch it back for the vertical add
    assign ram_req.we    = in_fire && pair_ok && !row_reg[0];
    assign ram_req.re    = in_fire && pair_ok && row_reg[0];
    assign ram_req.addr  = col_reg[rbd_pkg::COL_W-1:1];
    assign ram_req.wdata = pair_sum;

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        held_next = held_reg;
        if (restart) begin
            col_next = '0;
            row_next = '0;
        end else if (in_fire) begin
            if (track) begin
                if (!col_last) begin
                    col_next = col_reg + rbd_pkg::COL_W'(1);
                end else begin
                    col_next = '0;
                    row_next = row_reg + rbd_pkg::ROW_W'(1);
                end
            end
            if (in_beat.fe || fe_here) begin
                col_next = '0;
                row_next = '0;
            end
            if (proc && !drop && !col_reg[0]) begin
                held_next = in_beat.pix;
            end
        end
    end

    always_comb begin
        a_valid_next = a_valid_reg;
        a_comb_next  = a_comb_reg;
        a_pass_next  = a_pass_reg;
        a_fe_next    = a_fe_reg;
        a_pix_next   = a_pix_reg;
        a_pair_next  = a_pair_reg;
        if (in_fire) begin
            a_comb_next  = pair_ok && row_reg[0];
            a_pass_next  = in_beat.have && !cfg.active;
            a_fe_next    = in_beat.fe || fe_here;
            a_pix_next   = in_beat.pix;
            a_pair_next  = pair_sum;
            // beats with nothing to carry become bubbles here
            a_valid_next = (pair_ok && row_reg[0]) || (in_beat.have && !cfg.active)
                           || in_beat.fe || fe_here;
        end else if (b_ready) begin
            a_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_beat_next = out_beat_reg;
        if (b_ready) begin
            out_beat_next.valid = a_valid_reg;
            out_beat_next.have  = a_valid_reg && (a_comb_reg || a_pass_reg);
            out_beat_next.fe    = a_valid_reg && a_fe_reg;
            out_beat_next.pix   = a_comb_reg ? rbd_pkg::combine(ram_rdata, a_pair_reg)
                                             : a_pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            a_valid_reg  <= 1'b0;
            out_beat_reg <= '0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            a_valid_reg  <= a_valid_next;
            out_beat_reg <= out_beat_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg   <= held_next;
        a_comb_reg <= a_comb_next;
        a_pass_reg <= a_pass_next;
        a_fe_reg   <= a_fe_next;
        a_pix_reg  <= a_pix_next;
        a_pair_reg <= a_pair_next;
    end

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg.wk != '0) |-> (col_ext < cfg.wk))
        else $error("column position ran past stage width");

    a_stage_a_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && !b_ready) |=>
            (a_valid_reg && $stable(a_pair_reg) && $stable(a_comb_reg)))
        else $error("stage a lost its beat during a stall");

endmodule

`default_nettype wire

[rtl/rgba_box_downsample_cascade.sv]
// rgba_box_downsample_cascade: top level, apb registers, cell chain with
// line stores, and the output stage. depends on rbd_pkg, rbd_cell, rbd_ram.
//
//   channel  | ports                               | direction
//   ---------+-------------------------------------+----------
//   config   | psel penable pwrite paddr pwdata    | in / prdata pready out
//   pixel in | s_valid s_ready s_pixel_in          | in
//   pixel out| m_valid m_ready m_pixel_out         | out, with m_last_pixel
//
// one pixel beat is accepted per clock when nothing stalls; the chain of
// halving cells is two register stages per cell plus one output register.
// rate is set by each cell's single-port line store, used once per beat.
// a stall on m_ready backs up stage by stage; empty stages keep accepting.
// reset clears positions and counts at once; line stores need no clearing,
// since every pair sum is written on an even row before it is read.
`default_nettype none

module rgba_box_downsample_cascade (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rbd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [rbd_pkg::PDATA_W-1:0] pwdata,
    output logic      [rbd_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [rbd_pkg::PIX_W-1:0]   s_pixel_in,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic      [rbd_pkg::PIX_W-1:0]   m_pixel_out,
    output logic                             m_last_pixel
);

    localparam int NL = rbd_pkg::MAX_LEVELS;

    logic [rbd_pkg::DIM_W-1:0] width_reg, width_next;
    logic [rbd_pkg::DIM_W-1:0] height_reg, height_next;
    logic [rbd_pkg::LVL_W-1:0] levels_reg, levels_next;
    logic                      fake_reg, fake_next;

    logic [rbd_pkg::TOT_W-1:0] total_reg, total_next;
    logic [rbd_pkg::CNT_W-1:0] count_reg, count_next;
    logic                      m_valid_reg, m_valid_next;
    logic [rbd_pkg::PIX_W-1:0] m_pix_reg, m_pix_next;
    logic                      m_last_reg, m_last_next;

    logic                      cfg_wr;
    rbd_pkg::reg_idx_t         cfg_idx;
    logic                      restart;

    logic [rbd_pkg::WK_W-1:0]  w_eff;
    logic [rbd_pkg::HK_W-1:0]  h_eff;
    logic [rbd_pkg::LV_W-1:0]  lv_eff;
    logic [rbd_pkg::WK_W-1:0]  w_out;
    logic [rbd_pkg::HK_W-1:0]  h_out;

    rbd_pkg::cell_cfg_t        cell_cfg  [NL];
    rbd_pkg::ram_req_t         ram_req   [NL];
    logic [rbd_pkg::SUM_W-1:0] ram_rdata [NL];
    rbd_pkg::beat_t            chain     [NL+1];
    logic                      chain_ready [NL+1];

    logic                      fin_fire;
    logic [rbd_pkg::TOT_W-1:0] count_inc;
    logic                      is_last;
    logic [rbd_pkg::PIX_W-1:0] fin_pix;

    // register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = rbd_pkg::reg_idx_t'(paddr[3:2]);
    assign restart = cfg_wr;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        levels_next = levels_reg;
        fake_next   = fake_reg;
        if (cfg_wr) begin
            case (cfg_idx)
                rbd_pkg::REG_IMAGE_WIDTH:    width_next  = pwdata[rbd_pkg::DIM_W-1:0];
                rbd_pkg::REG_IMAGE_HEIGHT:   height_next = pwdata[rbd_pkg::DIM_W-1:0];
                rbd_pkg::REG_HALVING_LEVELS: levels_next = pwdata[rbd_pkg::LVL_W-1:0];
                rbd_pkg::REG_FAKE_ALPHA:     fake_next   = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            rbd_pkg::REG_IMAGE_WIDTH:    prdata = rbd_pkg::PDATA_W'(width_reg);
            rbd_pkg::REG_IMAGE_HEIGHT:   prdata = rbd_pkg::PDATA_W'(height_reg);
            rbd_pkg::REG_HALVING_LEVELS: prdata = rbd_pkg::PDATA_W'(levels_reg);
            rbd_pkg::REG_FAKE_ALPHA:     prdata = rbd_pkg::PDATA_W'(fake_reg);
            default:                     prdata = '0;
        endcase
    end

    // clamp the raw register values into working ranges
    always_comb begin
        if (width_reg == '0) begin
            w_eff = rbd_pkg::WK_W'(1);
        end else if (32'(width_reg) > rbd_pkg::MAX_WIDTH) begin
            w_eff = rbd_pkg::WK_W'(rbd_pkg::MAX_WIDTH);
        end else begin
            w_eff = rbd_pkg::WK_W'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = rbd_pkg::HK_W'(1);
        end else if (32'(height_reg) > rbd_pkg::HEIGHT_CAP) begin
            h_eff = rbd_pkg::HK_W'(rbd_pkg::HEIGHT_CAP);
        end else begin
            h_eff = rbd_pkg::HK_W'(height_reg);
        end
        if (32'(levels_reg) > rbd_pkg::MAX_LEVELS) begin
            lv_eff = rbd_pkg::LV_W'(rbd_pkg::MAX_LEVELS);
        end else begin
            lv_eff = rbd_pkg::LV_W'(levels_reg);
        end
    end

    assign w_out      = w_eff >> lv_eff;
    assign h_out      = h_eff >> lv_eff;
    assign total_next = rbd_pkg::TOT_W'(w_out) * rbd_pkg::TOT_W'(h_out);

    // cell chain
    assign chain[0] = '{valid: s_valid, have: 1'b1, fe: 1'b0, pix: s_pixel_in};
    assign s_ready  = chain_ready[0];

    for (genvar k = 0; k < NL; k++) begin : gen_cell
        localparam int RAM_DEPTH = ((rbd_pkg::MAX_WIDTH >> (k + 1)) > 1)
                                   ? (rbd_pkg::MAX_WIDTH >> (k + 1)) : 2;
        localparam int RAM_AW    = $clog2(RAM_DEPTH);

        logic [rbd_pkg::WK_W-1:0] wk;
        logic [rbd_pkg::HK_W-1:0] hk;

        assign wk = w_eff >> k;
        assign hk = h_eff >> k;
        assign cell_cfg[k] = '{
            active: (lv_eff > rbd_pkg::LV_W'(k)),
            head:   ((k == 0) ? 1'b1 : 1'b0),
            wk:     wk,
            hk:     hk,
            w_even: {wk[rbd_pkg::WK_W-1:1], 1'b0},
            h_even: {hk[rbd_pkg::HK_W-1:1], 1'b0}
        };

        rbd_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .restart   (restart),
            .cfg       (cell_cfg[k]),
            .in_beat   (chain[k]),
            .in_ready  (chain_ready[k]),
            .out_beat  (chain[k+1]),
            .out_ready (chain_ready[k+1]),
            .ram_req   (ram_req[k]),
            .ram_rdata (ram_rdata[k])
        );

        rbd_ram #(
            .DEPTH (RAM_DEPTH),
            .WIDTH (rbd_pkg::SUM_W)
        ) u_line (
            .aclk  (aclk),
            .we    (ram_req[k].we),
            .re    (ram_req[k].re),
            .addr  (ram_req[k].addr[RAM_AW-1:0]),
            .wdata (ram_req[k].wdata),
            .rdata (ram_rdata[k])
        );
    end

    // output stage: fake alpha, frame count and last flag
    assign chain_ready[NL] = !m_valid_reg || m_ready;
    assign fin_fire        = chain[NL].valid && chain_ready[NL];
    assign count_inc       = rbd_pkg::TOT_W'(count_reg) + rbd_pkg::TOT_W'(1);
    assign is_last         = count_inc >= total_reg;
    assign fin_pix         = (fake_reg && (chain[NL].pix[23:0] == 24'd0))
                             ? '0 : chain[NL].pix;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_pix_next   = m_pix_reg;
        m_last_next  = m_last_reg;
        count_next   = count_reg;
        if (restart) begin
            count_next = '0;
        end else if (fin_fire) begin
            m_valid_next = chain[NL].have;
            if (chain[NL].have) begin
                m_pix_next  = fin_pix;
                m_last_next = is_last;
                count_next  = is_last ? '0 : (count_reg + rbd_pkg::CNT_W'(1));
            end
            if (chain[NL].fe) begin
                count_next = '0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_out  = m_pix_reg;
    assign m_last_pixel = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= rbd_pkg::DIM_W'(2048);
            height_reg  <= rbd_pkg::DIM_W'(2048);
            levels_reg  <= '0;
            fake_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            levels_reg  <= levels_next;
            fake_reg    <= fake_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        total_reg  <= total_next;
        m_pix_reg  <= m_pix_next;
        m_last_reg <= m_last_next;
    end

    a_count_below_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (total_reg != '0) |-> (rbd_pkg::TOT_W'(count_reg) < total_reg))
        else $error("output count reached frame total");

    a_frame_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (fin_fire && chain[NL].fe) |=> (count_reg == '0))
        else $error("frame end beat did not clear output count");

endmodule

`default_nettype wire
